// ===== sv/tsft_pkg.sv =====
// ----------------------------------------------------------------------------
// tsft_pkg
// Types and constants shared by the triangle strip frustum test block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsft_pkg;

   localparam int COORD_WIDTH  = 16;
   localparam int PLANE_COUNT  = 4;
   localparam int COMP_WIDTH   = 16;
   localparam int OFFSET_SHIFT = 14;
   localparam int MARGIN_WIDTH = 31;
   localparam int PLANE_WIDTH  = 4 * COMP_WIDTH;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int SIDE_WIDTH   = 2;
   localparam int FILL_WIDTH   = 2;

   localparam logic [MARGIN_WIDTH-1:0] MARGIN_RESET = MARGIN_WIDTH'(16);
   localparam logic [FILL_WIDTH-1:0]   FILL_FULL    = FILL_WIDTH'(2);

   // side codes
   localparam logic [SIDE_WIDTH-1:0] SIDE_ON    = 2'd0;
   localparam logic [SIDE_WIDTH-1:0] SIDE_FRONT = 2'd1;
   localparam logic [SIDE_WIDTH-1:0] SIDE_BACK  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LEFT_PLANE   = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RIGHT_PLANE  = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TOP_PLANE    = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BOTTOM_PLANE = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ON_MARGIN    = 3'd4;

   typedef struct packed {
      logic signed [COMP_WIDTH-1:0] offset;
      logic signed [COMP_WIDTH-1:0] normal_z;
      logic signed [COMP_WIDTH-1:0] normal_y;
      logic signed [COMP_WIDTH-1:0] normal_x;
   } plane_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] vertex_x;
      logic signed [COORD_WIDTH-1:0] vertex_y;
      logic signed [COORD_WIDTH-1:0] vertex_z;
      logic                          strip_start;
      logic                          mesh_start;
   } req_payload_type;

   typedef struct packed {
      logic triangle_formed;
      logic triangle_touches;
      logic mesh_hit;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== sv/triangle_strip_frustum_test.sv =====
// ----------------------------------------------------------------------------
// triangle_strip_frustum_test
// Classifies strip vertices against four planes and flags triangles that
// touch the volume, with a sticky per-mesh hit flag.
// ----------------------------------------------------------------------------
//
//   channel   ports                         dir   handshake
//   request   req_valid/req_stall/req_*     in    valid, stall
//   response  rsp_valid/rsp_stall/rsp_*     out   valid, stall
//   config    csr_valid/csr_ready/csr_*     in    valid, ready
//
// one vertex per cycle while the response is not stalled; an input register and
// a result register with the whole plane test between them, so a request
// goes first into the input register and then into the result register
// the twelve plane products run in parallel, one multiplier per term
// reset is synchronous and clears valids, strip state and planes; margin resets to 16
// a stalled response holds both registers and raises req_stall
`default_nettype none

module triangle_strip_frustum_test (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire tsft_pkg::req_payload_type     req_payload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output tsft_pkg::rsp_payload_type          rsp_payload,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tsft_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [tsft_pkg::PLANE_WIDTH-1:0]   csr_data
);

   localparam int CW  = tsft_pkg::COORD_WIDTH;
   localparam int NP  = tsft_pkg::PLANE_COUNT;
   localparam int PW  = CW + tsft_pkg::COMP_WIDTH;
   localparam int OW  = tsft_pkg::COMP_WIDTH + tsft_pkg::OFFSET_SHIFT;
   localparam int BW  = (PW > OW) ? PW : OW;
   localparam int BW2 = (BW > tsft_pkg::MARGIN_WIDTH) ? BW : tsft_pkg::MARGIN_WIDTH;
   localparam int DW  = BW2 + 2;
   localparam int SW  = tsft_pkg::SIDE_WIDTH;

   // config registers
   tsft_pkg::plane_type                  plane_ff [NP];
   logic [tsft_pkg::MARGIN_WIDTH-1:0]    margin_ff;

   // input and result registers
   logic                                 adv;
   logic                                 s0_valid_ff;
   tsft_pkg::req_payload_type            s0_ff;
   logic signed [PW-1:0]                 prod [NP][3];
   logic signed [DW-1:0]                 distance [NP];

   // strip state
   logic [NP*SW-1:0]                     prev_ff, prev2_ff, cur_sides;
   logic [tsft_pkg::FILL_WIDTH-1:0]      fill_ff, fill_in, fill_eff;
   logic                                 hit_ff, hit_in;
   logic                                 rsp_valid_ff;
   tsft_pkg::rsp_payload_type            rsp_ff, rsp_in;

   assign csr_ready = 1'b1;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NP; k++) begin
            plane_ff[k] <= '0;
         end
         margin_ff <= tsft_pkg::MARGIN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tsft_pkg::CSR_LEFT_PLANE:   plane_ff[0] <= csr_data;
            tsft_pkg::CSR_RIGHT_PLANE:  plane_ff[1] <= csr_data;
            tsft_pkg::CSR_TOP_PLANE:    plane_ff[2] <= csr_data;
            tsft_pkg::CSR_BOTTOM_PLANE: plane_ff[3] <= csr_data;
            tsft_pkg::CSR_ON_MARGIN:    margin_ff <= csr_data[tsft_pkg::MARGIN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // products of normal and coordinate
   always_comb begin
      for (int k = 0; k < NP; k++) begin
         prod[k][0] = PW'(plane_ff[k].normal_x * s0_ff.vertex_x);
         prod[k][1] = PW'(plane_ff[k].normal_y * s0_ff.vertex_y);
         prod[k][2] = PW'(plane_ff[k].normal_z * s0_ff.vertex_z);
      end
   end

   // signed distance in units of 2^-14
   always_comb begin
      for (int k = 0; k < NP; k++) begin
         distance[k] = DW'(prod[k][0]) + DW'(prod[k][1]) + DW'(prod[k][2])
                     + (DW'(plane_ff[k].offset) <<< tsft_pkg::OFFSET_SHIFT);
      end
   end

   // side codes and triangle test
   always_comb begin
      logic signed [DW-1:0] m_pos;
      logic                 outside;
      logic                 any_front;
      logic                 any_back;
      logic [SW-1:0]        a, b, c;
      m_pos     = $signed(DW'(margin_ff));
      outside   = 1'b0;
      cur_sides = '0;
      for (int k = 0; k < NP; k++) begin
         if (distance[k] > m_pos) begin
            cur_sides[k*SW +: SW] = tsft_pkg::SIDE_FRONT;
         end else if (distance[k] < -m_pos) begin
            cur_sides[k*SW +: SW] = tsft_pkg::SIDE_BACK;
         end else begin
            cur_sides[k*SW +: SW] = tsft_pkg::SIDE_ON;
         end
      end
      for (int k = 0; k < NP; k++) begin
         a = prev2_ff[k*SW +: SW];
         b = prev_ff[k*SW +: SW];
         c = cur_sides[k*SW +: SW];
         any_front = (a == tsft_pkg::SIDE_FRONT) || (b == tsft_pkg::SIDE_FRONT)
                  || (c == tsft_pkg::SIDE_FRONT);
         any_back  = (a == tsft_pkg::SIDE_BACK) || (b == tsft_pkg::SIDE_BACK)
                  || (c == tsft_pkg::SIDE_BACK);
         if (any_front && !any_back) begin
            outside = 1'b1;
         end
      end
      fill_eff = s0_ff.strip_start ? '0 : fill_ff;
      rsp_in.triangle_formed  = (fill_eff >= tsft_pkg::FILL_FULL);
      rsp_in.triangle_touches = rsp_in.triangle_formed && !outside;
      hit_in = (s0_ff.mesh_start ? 1'b0 : hit_ff) | rsp_in.triangle_touches;
      rsp_in.mesh_hit = hit_in;
      fill_in = (fill_eff < tsft_pkg::FILL_FULL) ? fill_eff + 1'b1 : fill_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         prev2_ff     <= '0;
         fill_ff      <= '0;
         hit_ff       <= 1'b0;
      end else if (adv) begin
         s0_valid_ff  <= req_valid;
         rsp_valid_ff <= s0_valid_ff;
         if (s0_valid_ff) begin
            prev2_ff <= prev_ff;
            prev_ff  <= cur_sides;
            fill_ff  <= fill_in;
            hit_ff   <= hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff  <= req_payload;
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/tsft_checker.sv =====
// ----------------------------------------------------------------------------
// tsft_checker
// Port-level checks for the triangle strip frustum test block.
// ----------------------------------------------------------------------------
`default_nettype none

module tsft_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire tsft_pkg::rsp_payload_type rsp_payload
);

   // held response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // full pipeline pushes back on requests
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request not stalled behind a stalled response");

   // every request transfer reaches the result register
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 rsp_valid)
      else $error("no response after a request transfer");

   a_touch_formed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.triangle_touches |-> rsp_payload.triangle_formed)
      else $error("touch without a triangle");

   a_touch_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.triangle_touches |-> rsp_payload.mesh_hit)
      else $error("touch without mesh hit");

endmodule

bind triangle_strip_frustum_test tsft_checker u_tsft_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ===== tb/tb_triangle_strip_frustum_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_strip_frustum_test
// Self-checking bench for the triangle strip frustum test block.
// Streams strip vertices through the request channel, predicts the per-vertex
// side codes, triangle formation, touch result and sticky mesh hit, and
// compares every response transfer in order. Plane and margin registers are
// reloaded between phases: reset values, zero normals, field extremes, box
// frusta and random planes, with random idling, a long output hold and a
// sender pause.
// ----------------------------------------------------------------------------

module tb_triangle_strip_frustum_test;

   localparam int HALF_PERIOD = 6;
   localparam int DATA_WIDTH  = tsft_pkg::PLANE_WIDTH;
   localparam int IDX_WIDTH   = tsft_pkg::CSR_IDX_WIDTH;
   localparam int COMP_W      = tsft_pkg::COMP_WIDTH;
   localparam int COORD_W     = tsft_pkg::COORD_WIDTH;
   localparam int SIDE_W      = tsft_pkg::SIDE_WIDTH;
   localparam logic [DATA_WIDTH-1:0] MARGIN_DEFAULT = DATA_WIDTH'(tsft_pkg::MARGIN_RESET);
   localparam logic [DATA_WIDTH-1:0] MARGIN_FULL =
      DATA_WIDTH'({tsft_pkg::MARGIN_WIDTH{1'b1}});

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   tsft_pkg::req_payload_type             req_payload;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   tsft_pkg::rsp_payload_type             rsp_payload;
   logic                                  csr_valid;
   logic                                  csr_ready;
   logic [IDX_WIDTH-1:0]                  csr_index;
   logic [DATA_WIDTH-1:0]                 csr_data;

   // predictor state
   tsft_pkg::plane_type                   plane_cfg [tsft_pkg::PLANE_COUNT] = '{default: '0};
   logic [tsft_pkg::MARGIN_WIDTH-1:0]     margin_cfg = tsft_pkg::MARGIN_RESET;
   logic [2*tsft_pkg::PLANE_COUNT-1:0]    last_sides = '0;
   logic [2*tsft_pkg::PLANE_COUNT-1:0]    older_sides = '0;
   logic [tsft_pkg::FILL_WIDTH-1:0]       strip_depth = '0;
   logic                                  mesh_hit_state = 1'b0;
   tsft_pkg::rsp_payload_type             expected_flags [$];

   bit                         sender_idling = 1'b1;
   bit                         receiver_idling = 1'b1;
   int                         hold_cycles = 0;
   int                         failures = 0;
   int                         vertices_sent = 0;
   int                         triangles_formed = 0;
   int                         triangles_touching = 0;
   int                         register_writes = 0;

   triangle_strip_frustum_test dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic tsft_pkg::plane_type make_plane(input int nx, input int ny,
                                                      input int nz, input int offset);
      tsft_pkg::plane_type p;
      p.normal_x = COMP_W'(nx);
      p.normal_y = COMP_W'(ny);
      p.normal_z = COMP_W'(nz);
      p.offset   = COMP_W'(offset);
      return p;
   endfunction

   function automatic tsft_pkg::req_payload_type make_vertex(input int x, input int y,
                                                             input int z, input bit strip,
                                                             input bit mesh);
      tsft_pkg::req_payload_type v;
      v.vertex_x    = COORD_W'(x);
      v.vertex_y    = COORD_W'(y);
      v.vertex_z    = COORD_W'(z);
      v.strip_start = strip;
      v.mesh_start  = mesh;
      return v;
   endfunction

   function automatic int random_coord(input int span);
      if ($urandom_range(9) == 0)
         return int'($urandom);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic [SIDE_W-1:0] side_of(input tsft_pkg::plane_type p,
                                                 input tsft_pkg::req_payload_type v);
      longint distance;
      longint limit;
      distance = longint'(p.normal_x) * longint'(v.vertex_x)
               + longint'(p.normal_y) * longint'(v.vertex_y)
               + longint'(p.normal_z) * longint'(v.vertex_z)
               + longint'(p.offset) * (longint'(1) << tsft_pkg::OFFSET_SHIFT);
      limit = longint'(margin_cfg);
      if (distance > limit)
         return tsft_pkg::SIDE_FRONT;
      if (distance < -limit)
         return tsft_pkg::SIDE_BACK;
      return tsft_pkg::SIDE_ON;
   endfunction

   task automatic predict_vertex(input tsft_pkg::req_payload_type v);
      logic [2*tsft_pkg::PLANE_COUNT-1:0] cur_sides;
      logic [SIDE_W-1:0]                  a, b, c;
      logic                               outside;
      tsft_pkg::rsp_payload_type          r;
      int                                 k;
      if (v.strip_start)
         strip_depth = '0;
      if (v.mesh_start)
         mesh_hit_state = 1'b0;
      for (k = 0; k < tsft_pkg::PLANE_COUNT; k++)
         cur_sides[SIDE_W*k +: SIDE_W] = side_of(plane_cfg[k], v);
      r = '0;
      if (strip_depth >= tsft_pkg::FILL_FULL) begin
         r.triangle_formed = 1'b1;
         outside = 1'b0;
         for (k = 0; k < tsft_pkg::PLANE_COUNT; k++) begin
            a = older_sides[SIDE_W*k +: SIDE_W];
            b = last_sides[SIDE_W*k +: SIDE_W];
            c = cur_sides[SIDE_W*k +: SIDE_W];
            if ((a == tsft_pkg::SIDE_FRONT || b == tsft_pkg::SIDE_FRONT ||
                 c == tsft_pkg::SIDE_FRONT) &&
                !(a == tsft_pkg::SIDE_BACK || b == tsft_pkg::SIDE_BACK ||
                  c == tsft_pkg::SIDE_BACK))
               outside = 1'b1;
         end
         triangles_formed++;
         if (!outside) begin
            r.triangle_touches = 1'b1;
            mesh_hit_state = 1'b1;
            triangles_touching++;
         end
      end
      older_sides = last_sides;
      last_sides = cur_sides;
      if (strip_depth < tsft_pkg::FILL_FULL)
         strip_depth++;
      r.mesh_hit = mesh_hit_state;
      expected_flags = {expected_flags, r};
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_vertex(input tsft_pkg::req_payload_type vtx);
      while (sender_idling && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= vtx;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_vertex(vtx);
      vertices_sent++;
      @(negedge clock);
   endtask

   task automatic write_register(input logic [IDX_WIDTH-1:0] index,
                                 input logic [DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (index)
         tsft_pkg::CSR_LEFT_PLANE, tsft_pkg::CSR_RIGHT_PLANE,
         tsft_pkg::CSR_TOP_PLANE, tsft_pkg::CSR_BOTTOM_PLANE: begin
            plane_cfg[index[1:0]] = value;
         end
         tsft_pkg::CSR_ON_MARGIN: begin
            margin_cfg = value[tsft_pkg::MARGIN_WIDTH-1:0];
         end
         default: begin
         end
      endcase
      register_writes++;
      @(negedge clock);
   endtask

   // waits until the block is idle: no request pending and every response back
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_flags.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic load_config(input tsft_pkg::plane_type left,
                              input tsft_pkg::plane_type right,
                              input tsft_pkg::plane_type top,
                              input tsft_pkg::plane_type bottom,
                              input logic [DATA_WIDTH-1:0] margin);
      settle();
      write_register(tsft_pkg::CSR_LEFT_PLANE, left);
      write_register(tsft_pkg::CSR_RIGHT_PLANE, right);
      write_register(tsft_pkg::CSR_TOP_PLANE, top);
      write_register(tsft_pkg::CSR_BOTTOM_PLANE, bottom);
      write_register(tsft_pkg::CSR_ON_MARGIN, margin);
      csr_valid <= 1'b0;
   endtask

   task automatic load_box(input int width, input logic [DATA_WIDTH-1:0] margin);
      load_config(make_plane(-16384, 0, 0, -width), make_plane(16384, 0, 0, -width),
                  make_plane(0, 16384, 0, -width), make_plane(0, -16384, 0, -width),
                  margin);
   endtask

   task automatic load_random_planes(input logic [DATA_WIDTH-1:0] margin);
      load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, margin);
   endtask

   // mostly well-formed strips, with some stray strip and mesh marks
   task automatic run_strips(input int count, input int span);
      tsft_pkg::req_payload_type v;
      int                        sent;
      int                        strip_len;
      int                        pos;
      sent = 0;
      while (sent < count) begin
         strip_len = $urandom_range(1, 9);
         for (pos = 0; pos < strip_len && sent < count; pos++) begin
            v = make_vertex(random_coord(span), random_coord(span), random_coord(span),
                            pos == 0, (pos == 0) && ($urandom_range(5) == 0));
            if ($urandom_range(19) == 0) begin
               v.strip_start = 1'($urandom_range(1));
               v.mesh_start  = 1'($urandom_range(1));
            end
            send_vertex(v);
            sent++;
         end
      end
   endtask

   task automatic test_reset_defaults();
      // zero planes: every vertex on every plane, so each triangle touches
      send_vertex(make_vertex(100, -100, 5, 1'b1, 1'b1));
      send_vertex(make_vertex(-7, 3, 0, 1'b0, 1'b0));
      send_vertex(make_vertex(0, 0, 0, 1'b0, 1'b0));
      send_vertex(make_vertex(32767, -32768, 1, 1'b0, 1'b0));
   endtask

   task automatic test_zero_normal();
      load_config(make_plane(0, 0, 0, 1), '0, '0, '0, MARGIN_DEFAULT);
      send_vertex(make_vertex(-32768, 0, 0, 1'b1, 1'b1));
      send_vertex(make_vertex(32767, 32767, 32767, 1'b0, 1'b0));
      send_vertex(make_vertex(5, -5, 5, 1'b0, 1'b0));
      load_config(make_plane(0, 0, 0, -1), '0, '0, '0, MARGIN_DEFAULT);
      send_vertex(make_vertex(1, 2, 3, 1'b1, 1'b0));
      send_vertex(make_vertex(-1, -2, -3, 1'b0, 1'b0));
      send_vertex(make_vertex(0, 0, 0, 1'b0, 1'b0));
   endtask

   task automatic test_field_extremes();
      load_config(make_plane(-32768, 0, 0, 0), make_plane(0, 32767, 0, 32767),
                  make_plane(0, 0, -32768, -32768), make_plane(32767, 32767, 32767, 0),
                  '0);
      send_vertex(make_vertex(-32768, -32768, -32768, 1'b1, 1'b0));
      send_vertex(make_vertex(32767, 32767, 32767, 1'b0, 1'b0));
      send_vertex(make_vertex(0, 0, 0, 1'b0, 1'b1));
      send_vertex(make_vertex(-32768, 32767, 0, 1'b1, 1'b0));
      send_vertex(make_vertex(32767, -32768, -32768, 1'b0, 1'b0));
      send_vertex(make_vertex(1, -1, 0, 1'b0, 1'b0));
      send_vertex(make_vertex(-1, 1, 1, 1'b0, 1'b0));
      // margin at full scale, upper data bits set
      settle();
      write_register(tsft_pkg::CSR_ON_MARGIN, '1);
      csr_valid <= 1'b0;
      send_vertex(make_vertex(-32768, -32768, 32767, 1'b1, 1'b1));
      send_vertex(make_vertex(32767, 32767, -32768, 1'b0, 1'b0));
      send_vertex(make_vertex(-32768, 32767, -32768, 1'b0, 1'b0));
   endtask

   task automatic test_unused_index();
      int idx;
      load_box(800, MARGIN_DEFAULT);
      for (idx = int'(tsft_pkg::CSR_ON_MARGIN) + 1; idx < (1 << IDX_WIDTH); idx++)
         write_register(IDX_WIDTH'(idx), {$urandom, $urandom});
      csr_valid <= 1'b0;
      send_vertex(make_vertex(0, 0, 0, 1'b1, 1'b1));
      send_vertex(make_vertex(20000, 0, 0, 1'b0, 1'b0));
      send_vertex(make_vertex(-20000, 0, 0, 1'b0, 1'b0));
   endtask

   task automatic test_random_traffic();
      int width;
      width = $urandom_range(16, 4000);
      load_box(width, MARGIN_DEFAULT);
      run_strips(250, (2 * width > 32767) ? 32767 : 2 * width);
      // stretch without any idling on either side
      load_random_planes(DATA_WIDTH'($urandom_range(0, 1 << 20)));
      sender_idling = 1'b0;
      receiver_idling = 1'b0;
      run_strips(200, 32767);
      sender_idling = 1'b1;
      receiver_idling = 1'b1;
      width = $urandom_range(16, 4000);
      load_box(width, '0);
      run_strips(200, (2 * width > 32767) ? 32767 : 2 * width);
      load_random_planes({$urandom, $urandom});
      run_strips(150, 32767);
      load_box($urandom_range(16, 4000), MARGIN_FULL);
      run_strips(100, 32767);
   endtask

   task automatic test_output_backpressure();
      load_box(1200, MARGIN_DEFAULT);
      hold_cycles = 120;
      run_strips(30, 2400);
   endtask

   task automatic test_sender_pause();
      int n;
      run_strips(20, 2400);
      settle();
      // the strip carries on across the pause
      for (n = 0; n < 3; n++)
         send_vertex(make_vertex(random_coord(2400), random_coord(2400),
                                 random_coord(2400), 1'b0, 1'b0));
      run_strips(17, 2400);
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall <= receiver_idling && ($urandom_range(99) < 12);
      end
   end

   always @(posedge clock) begin : check_results
      tsft_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_flags.size() == 0) begin
            $error("response transfer with nothing expected: %b", rsp_payload);
            failures++;
         end else begin
            want = expected_flags.pop_front();
            if (rsp_payload.triangle_formed !== want.triangle_formed) begin
               $error("triangle_formed expected %b actual %b",
                      want.triangle_formed, rsp_payload.triangle_formed);
               failures++;
            end
            if (rsp_payload.triangle_touches !== want.triangle_touches) begin
               $error("triangle_touches expected %b actual %b",
                      want.triangle_touches, rsp_payload.triangle_touches);
               failures++;
            end
            if (rsp_payload.mesh_hit !== want.mesh_hit) begin
               $error("mesh_hit expected %b actual %b", want.mesh_hit, rsp_payload.mesh_hit);
               failures++;
            end
         end
      end
   end

   initial begin
      #2ms;
      $error("run timed out with %0d responses outstanding", expected_flags.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_normal();
      test_field_extremes();
      test_unused_index();
      test_random_traffic();
      test_output_backpressure();
      test_sender_pause();
      settle();

      $display("covered %0d vertices, %0d triangles (%0d touching), %0d register writes",
               vertices_sent, triangles_formed, triangles_touching, register_writes);
      $display("phases: reset planes, zero normals, extremes, box frusta, random planes,");
      $display("        long output hold and a sender pause");
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
